### src/assert_macros.svh
// Assertion helpers used by the scheduler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mqsjs_pkg.sv
`timescale 1ns / 1ps
package mqsjs_pkg;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int LINE_W  = 4;
  localparam int ARR_W   = 30;
  localparam int SIZE_W  = 7;
  localparam int TAG_W   = 16;
  localparam int STAT_W  = 3;
  localparam int TIME_W  = 32;
  localparam int BASE_W  = 16;
  localparam int PIC_W   = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W  = PIC_W + SIZE_W;
  // Scheduling key: not-arrived flag over size or arrival
  localparam int KEY_W   = ARR_W + 1;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_ENQ    = 3'd0;
  localparam logic [STAT_W-1:0] ST_SERVED = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROP   = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEAR  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIC  = 1'd1;

  localparam logic [BASE_W-1:0] BASE_RST = 16'd30;
  localparam logic [PIC_W-1:0]  PIC_RST  = 8'd5;

  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } job_t;

  // Control from the sequencer to the pick unit
  typedef struct packed {
    logic clear;
    logic step;
  } pick_ctl_t;

endpackage

### src/mqsjs_if.sv
`timescale 1ns / 1ps
// Input channel: one scheduler command per transaction
interface mqsjs_in_if import mqsjs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LINE_W-1:0] line_number;
  logic [ARR_W-1:0]  arrival_time;
  logic [SIZE_W-1:0] ticket_count;
  logic [TAG_W-1:0]  customer_tag;

  modport source (output valid, kind, line_number, arrival_time, ticket_count,
                  customer_tag, input ready);
  modport sink (input valid, kind, line_number, arrival_time, ticket_count,
                customer_tag, output ready);
endinterface

// Result channel: one result per command
interface mqsjs_out_if import mqsjs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [LINE_W-1:0] served_line;
  logic [TAG_W-1:0]  served_tag;
  logic [TIME_W-1:0] finish_time;

  modport source (output valid, status, served_line, served_tag, finish_time,
                  input ready);
  modport sink (input valid, status, served_line, served_tag, finish_time,
                output ready);
endinterface

### src/mqsjs_job_ram.sv
`timescale 1ns / 1ps
// Job store: one write port, one registered read port
module mqsjs_job_ram import mqsjs_pkg::*; #(
  parameter int NUM_WORDS = 768,
  parameter int AW        = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  job_t          wdata,
  input  logic [AW-1:0] raddr,
  output job_t          rdata
);

  job_t mem [NUM_WORDS];
  job_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/mqsjs_pick_unit.sv
`timescale 1ns / 1ps
// Shared compare unit: one queue head per step, keeps the best so far.
// Arrived heads rank by size, others by arrival, arrived before not arrived;
// strict compare keeps the lowest queue on a tie.
module mqsjs_pick_unit import mqsjs_pkg::*; #(
  parameter int QW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pick_ctl_t         ctl,
  input  logic [TIME_W-1:0] clock_now,
  input  job_t              cand,
  input  logic [QW-1:0]     cand_q,
  output logic              best_found,
  output logic [QW-1:0]     best_q,
  output job_t              best_job
);

  logic             found_r;
  logic [KEY_W-1:0] key_r;
  logic [QW-1:0]    q_r;
  job_t             job_r;
  logic             arrived;
  logic [KEY_W-1:0] cand_key;
  logic             take;

  // Key forming and compare
  always_comb begin
    arrived  = {{(TIME_W-ARR_W){1'b0}}, cand.arrival} <= clock_now;
    cand_key = arrived ? {1'b0, {(ARR_W-SIZE_W){1'b0}}, cand.size}
                       : {1'b1, cand.arrival};
    take     = ctl.step && (!found_r || (cand_key < key_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= cand_key;
      q_r   <= cand_q;
      job_r <= cand;
    end
  end

  assign best_found = found_r;
  assign best_q     = q_r;
  assign best_job   = job_r;

endmodule

### src/multi_queue_shortest_job_scheduler_core.sv
`timescale 1ns / 1ps
// Multi-queue shortest-job scheduler.
// in_ch carries commands (enqueue, serve, clear clock); out_ch returns exactly
// one result per command, in order. cfg_we/cfg_index/cfg_wdata write
// base_cost (index 0) and per_item_cost (index 1); the user must do so only
// while the block is idle, which the block does not enforce. One command is
// in work at a time; in_ch.ready is high only when idle. Clear, unused code
// and bad-queue drop go straight to the result load; enqueue first passes
// the queue write state; serve first runs the head scan: one queue head is
// read from the job RAM and fed to the shared compare unit per cycle, then
// come the last compare, the cost multiply, the clock update and the result
// load. The next command is taken in the cycle after the result load.
// A finished result waits in the output register; the next command is
// accepted meanwhile, and its result waits until out_ch.ready takes the
// previous one.
// Reset (rst_n low, synchronous) empties every queue, zeroes the clock and
// loads the default costs; the job RAM itself is not cleared.
`include "assert_macros.svh"
module multi_queue_shortest_job_scheduler_core import mqsjs_pkg::*; #(
  parameter int NUM_QUEUES  = 12,
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_SIZE    = 100
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mqsjs_in_if.sink             in_ch,
  mqsjs_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int QW    = $clog2(NUM_QUEUES);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WORDS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(WORDS);
  localparam logic [AW-1:0]     DEPTH_A  = AW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]     LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0]  FULL_OCC = OCC_W'(QUEUE_DEPTH);
  localparam logic [QW-1:0]     LAST_Q   = QW'(NUM_QUEUES - 1);
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(MAX_SIZE);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENQ   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_COST  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;
  logic [BASE_W-1:0] base_r;
  logic [PIC_W-1:0]  pic_r;
  job_t              item_r;

  logic [PW-1:0]     head_r [NUM_QUEUES];
  logic [PW-1:0]     tail_r [NUM_QUEUES];
  logic [OCC_W-1:0]  occ_r  [NUM_QUEUES];
  logic              push, pop;

  logic              rd_v_r, rd_v_nxt;
  logic              rd_nz_r, rd_nz_nxt;
  logic [QW-1:0]     rd_q_r, rd_q_nxt;
  logic [PROD_W-1:0] prod_r;

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [LINE_W-1:0] res_line_r, res_line_nxt;
  logic [TAG_W-1:0]  res_tag_r, res_tag_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [LINE_W-1:0] out_line_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [TIME_W-1:0] out_time_r;
  logic              out_load;

  logic              in_fire;
  logic              line_ok;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  job_t              ram_rdata;
  job_t              enq_job;
  pick_ctl_t         pick_ctl;
  logic              best_found;
  logic [QW-1:0]     best_q;
  job_t              best_job;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W:0]   end_sum;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign line_ok     = (in_ch.line_number != '0) &&
                       (32'(in_ch.line_number) <= 32'(NUM_QUEUES));

  // Job RAM addressing: queue base plus slot
  assign ram_waddr = AW'(q_r) * DEPTH_A + AW'(tail_r[q_r]);
  assign ram_raddr = AW'(q_r) * DEPTH_A + AW'(head_r[q_r]);

  always_comb begin
    enq_job      = item_r;
    enq_job.size = (item_r.size > SIZE_CAP) ? SIZE_CAP : item_r.size;
  end

  mqsjs_job_ram #(
    .NUM_WORDS (WORDS),
    .AW        (AW)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (ram_waddr),
    .wdata (enq_job),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pick_ctl.clear = in_fire;
  assign pick_ctl.step  = rd_v_r && rd_nz_r;

  mqsjs_pick_unit #(
    .QW (QW)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pick_ctl),
    .clock_now  (clock_r),
    .cand       (ram_rdata),
    .cand_q     (rd_q_r),
    .best_found (best_found),
    .best_q     (best_q),
    .best_job   (best_job)
  );

  // Clock update: max(clock, arrival) + base + product, saturating
  always_comb begin
    start_time = ({{(TIME_W-ARR_W){1'b0}}, best_job.arrival} > clock_r) ?
                 {{(TIME_W-ARR_W){1'b0}}, best_job.arrival} : clock_r;
    end_sum    = {1'b0, start_time} + (TIME_W+1)'(base_r) + (TIME_W+1)'(prod_r);
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    clock_nxt      = clock_r;
    rd_v_nxt       = 1'b0;
    rd_nz_nxt      = 1'b0;
    rd_q_nxt       = q_r;
    res_status_nxt = res_status_r;
    res_line_nxt   = res_line_r;
    res_tag_nxt    = res_tag_r;
    push           = 1'b0;
    pop            = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_line_nxt = '0;
          res_tag_nxt  = '0;
          case (in_ch.kind)
            KIND_ENQ: begin
              if (line_ok) begin
                q_nxt     = QW'(in_ch.line_number - 1'b1);
                state_nxt = S_ENQ;
              end else begin
                res_status_nxt = ST_DROP;
                state_nxt      = S_DONE;
              end
            end
            KIND_SERVE: begin
              q_nxt     = '0;
              state_nxt = S_SCAN;
            end
            KIND_CLEAR: begin
              clock_nxt      = '0;
              res_status_nxt = ST_CLEAR;
              state_nxt      = S_DONE;
            end
            default: begin
              res_status_nxt = ST_NONE;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_ENQ: begin
        if (occ_r[q_r] >= FULL_OCC) begin
          res_status_nxt = ST_DROP;
        end else begin
          push           = 1'b1;
          res_status_nxt = ST_ENQ;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // Read head of queue q_r; compare it next cycle
        rd_v_nxt  = 1'b1;
        rd_nz_nxt = (occ_r[q_r] != '0);
        rd_q_nxt  = q_r;
        if (q_r == LAST_Q) begin
          state_nxt = S_DRAIN;
        end else begin
          q_nxt = q_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COST;
      end
      S_COST: begin
        if (best_found) begin
          q_nxt     = best_q;
          state_nxt = S_UPD;
        end else begin
          res_status_nxt = ST_NONE;
          state_nxt      = S_DONE;
        end
      end
      S_UPD: begin
        clock_nxt      = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
        pop            = 1'b1;
        res_status_nxt = ST_SERVED;
        res_line_nxt   = LINE_W'(32'(q_r) + 1);
        res_tag_nxt    = best_job.tag;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      q_r     <= '0;
      clock_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
      clock_r <= clock_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_nz_r      <= rd_nz_nxt;
    rd_q_r       <= rd_q_nxt;
    res_status_r <= res_status_nxt;
    res_line_r   <= res_line_nxt;
    res_tag_r    <= res_tag_nxt;
    prod_r       <= pic_r * best_job.size;
    if (in_fire) begin
      item_r.arrival <= in_ch.arrival_time;
      item_r.size    <= in_ch.ticket_count;
      item_r.tag     <= in_ch.customer_tag;
    end
  end

  // Queue pointers and fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        occ_r[i]  <= '0;
      end
    end else if (push) begin
      tail_r[q_r] <= (tail_r[q_r] == LAST_SLOT) ? '0 : tail_r[q_r] + 1'b1;
      occ_r[q_r]  <= occ_r[q_r] + 1'b1;
    end else if (pop) begin
      head_r[q_r] <= (head_r[q_r] == LAST_SLOT) ? '0 : head_r[q_r] + 1'b1;
      occ_r[q_r]  <= occ_r[q_r] - 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RST;
      pic_r  <= PIC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE: base_r <= cfg_wdata[BASE_W-1:0];
        CFG_PIC:  pic_r  <= cfg_wdata[PIC_W-1:0];
        default:  ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_line_r   <= res_line_r;
      out_tag_r    <= res_tag_r;
      out_time_r   <= clock_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.served_line = out_line_r;
  assign out_ch.served_tag  = out_tag_r;
  assign out_ch.finish_time = out_time_r;

  // Checks
  `ASSERT_CLK(a_one_at_a_time, in_fire |=> !in_ch.ready, "command accepted while busy")
  `ASSERT_CLK(a_clock_grows, state_r == S_UPD |=> clock_r >= $past(clock_r), "clock went back")
  `ASSERT_CLK(a_served_line, out_ch.valid && out_ch.status == ST_SERVED |-> out_ch.served_line != '0, "served without queue")
  `ASSERT_CLK(a_occ_bound, occ_r[q_r] <= FULL_OCC, "queue over capacity")
  `ASSERT_ALWAYS(a_pop_nonempty, pop |-> occ_r[q_r] != '0, "pop from empty queue")

endmodule
